### src/cnf_pkg.sv
package cnf_pkg;

	// default sizing
	localparam int NUM_SPECIES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 28;

	// fixed field widths
	localparam int IN_W  = 32;
	localparam int SUM_W = 32;

endpackage

### src/cnf_store.sv
module cnf_store import cnf_pkg::*; #(
	parameter int NUM_SPECIES = NUM_SPECIES_DEF,
	parameter int DW          = 29,
	localparam int AW         = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [NUM_SPECIES];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/cnf_div.sv
module cnf_div import cnf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NUM_W     = 29,
	localparam int CNT_W    = $clog2(FRAC_BITS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num,
	input  logic [SUM_W-1:0]     den,
	output logic                 done,
	output logic [FRAC_BITS-1:0] quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [SUM_W:0]       rem2;
	logic                 ge;
	logic [SUM_W:0]       rem_nxt;

	// one quotient bit per cycle, remainder stays below den
	assign rem2    = {rem_q, 1'b0};
	assign ge      = rem2 >= {1'b0, den};
	assign rem_nxt = ge ? (rem2 - {1'b0, den}) : rem2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
				rem_q  <= SUM_W'(num);
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q <= rem_nxt[SUM_W-1:0];
				quo_q <= {quo_q[FRAC_BITS-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### src/clamp_and_normalize_fractions.sv
// after the last request of a cell, each stored fraction is read, evaluated and, when
// below the sum of a cell neither covered nor zero-sum, divided by the restoring
// divider that yields one quotient bit per cycle; other values skip the divider;
// no new request is taken until every result of the cell is in the output register
// reset (arst_n low, asynchronous) empties the cell: sum, count, overflow and
// output valid are cleared; the fraction store needs no clearing
module clamp_and_normalize_fractions import cnf_pkg::*; #(
	parameter int NUM_SPECIES = NUM_SPECIES_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int OW         = FRAC_BITS + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [IN_W-1:0]   fraction,
	input  logic              covered,
	input  logic              last_species,
	// output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OW-1:0]     scaled_fraction,
	output logic              last_out,
	output logic              zero_sum,
	output logic              overflow
);

	// stored value width: clamped value never exceeds 1.0 nor 2^31-1
	localparam int VW   = (FRAC_BITS + 1 < IN_W) ? FRAC_BITS + 1 : IN_W - 1;
	localparam int CMPW = (FRAC_BITS + 2 > IN_W + 1) ? FRAC_BITS + 2 : IN_W + 1;
	localparam int CW   = $clog2(NUM_SPECIES + 1);
	localparam int AW   = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;

	localparam logic [CMPW-1:0] UNIT_CMP = CMPW'(1) << FRAC_BITS;
	localparam logic [OW-1:0]   UNIT_OUT = OW'(1) << FRAC_BITS;

	typedef enum logic [2:0] {
		S_COLLECT,  // taking requests of the current cell
		S_RD,       // read one stored fraction
		S_EVAL,     // pick pass-through, unit, zero, or start a divide
		S_DIV,      // wait on the serial divider
		S_PUT       // hand the result to the output register
	} state_t;

	state_t          state_q;
	logic [SUM_W-1:0] sum_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic            ovf_q;
	logic            cov_q;
	logic            zs_q;
	logic [OW-1:0]   res_q;

	logic            out_valid_q;
	logic [OW-1:0]   scaled_q;
	logic            last_q;
	logic            zs_out_q;
	logic            ovf_out_q;

	// input side
	logic            in_acc;
	logic            has_room;
	logic [CMPW-1:0] frac_pos;
	logic [VW-1:0]   clamped;
	logic [SUM_W:0]  sum_wide;
	logic [SUM_W-1:0] sum_nxt;

	// emit side
	logic [VW-1:0]   rd_data;
	logic            rd_en;
	logic            div_start;
	logic            div_done;
	logic [FRAC_BITS-1:0] div_quo;
	logic            out_free;
	logic            is_last;

	assign in_ready = (state_q == S_COLLECT);
	assign in_acc   = in_valid && in_ready;
	assign has_room = count_q < CW'(NUM_SPECIES);

	// clamp to [0, 1.0]: negative goes to zero, above one goes to one
	assign frac_pos = CMPW'(fraction[IN_W-2:0]);
	always_comb begin
		if (fraction[IN_W-1]) begin
			clamped = '0;
		end else if (frac_pos > UNIT_CMP) begin
			clamped = VW'(UNIT_CMP);
		end else begin
			clamped = VW'(frac_pos);
		end
	end

	// saturating running sum
	assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(clamped);
	assign sum_nxt  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

	cnf_store #(
		.NUM_SPECIES (NUM_SPECIES),
		.DW          (VW)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc && has_room),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (clamped),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign rd_en = (state_q == S_RD);

	// divide only when the value is below the sum, so the quotient stays under 1.0
	assign div_start = (state_q == S_EVAL) && !zs_q && !cov_q
		&& ({{(SUM_W - VW){1'b0}}, rd_data} < sum_q);

	cnf_div #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_W     (VW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rd_data),
		.den    (sum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || out_ready;
	assign is_last  = (idx_q + 1'b1) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			sum_q       <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			cov_q       <= 1'b0;
			zs_q        <= 1'b0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			scaled_q    <= '0;
			last_q      <= 1'b0;
			zs_out_q    <= 1'b0;
			ovf_out_q   <= 1'b0;
		end else begin
			// in S_PUT the output register is reloaded below
			if (out_valid_q && out_ready && (state_q != S_PUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_COLLECT: begin
					if (in_acc) begin
						if (has_room) begin
							count_q <= count_q + 1'b1;
							sum_q   <= sum_nxt;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_species) begin
							// closing request: covered comes from it, even when dropped
							cov_q   <= covered;
							zs_q    <= has_room ? (sum_nxt == '0) : (sum_q == '0);
							idx_q   <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (zs_q) begin
						res_q   <= '0;
						state_q <= S_PUT;
					end else if (cov_q) begin
						res_q   <= OW'(rd_data);
						state_q <= S_PUT;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else begin
						// value not below the sum, exactly one
						res_q   <= UNIT_OUT;
						state_q <= S_PUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= OW'(div_quo);
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						scaled_q    <= res_q;
						last_q      <= is_last;
						zs_out_q    <= zs_q;
						ovf_out_q   <= ovf_q;
						if (is_last) begin
							// cell done, start the next one clean
							sum_q   <= '0;
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_COLLECT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign scaled_fraction = scaled_q;
	assign last_out        = last_q;
	assign zero_sum        = zs_out_q;
	assign overflow        = ovf_out_q;

	// read index stays inside the filled part of the store while emitting
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_COLLECT) |-> (idx_q < count_q))
		else $error("emit index beyond stored count");

	// fill count never passes capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_SPECIES))
		else $error("species count beyond capacity");

	// no result ever above one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scaled_fraction <= UNIT_OUT))
		else $error("result above one");

	// a zero-sum cell gives only zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_sum) |-> (scaled_fraction == '0))
		else $error("nonzero result on zero sum");

	// the divider finishes only while the control waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside divide wait");

endmodule
